FILE: rtl/ebcpu_pkg.sv
// ----------------------------------------------------------------------------
// ebcpu_pkg
// shared types and constants for the eight-bit cpu core step block
// ----------------------------------------------------------------------------
package ebcpu_pkg;

    localparam int ROM_DEPTH_DEF = 32768;
    localparam int RAM_DEPTH_DEF = 32768;

    // alu operations
    typedef enum logic [2:0] {
        ALU_LOAD,
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_OR,
        ALU_XOR,
        ALU_INC,
        ALU_DEC
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
        logic    carry_en;
    } alu_ctl_t;

    // one byte access on the shared memory port
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;

    // flag bit positions
    localparam int FL_Z = 0;
    localparam int FL_C = 1;
    localparam int FL_N = 2;
    localparam int FL_V = 3;

endpackage

FILE: rtl/eight_bit_cpu_core_step.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_core_step
// 8-bit cpu core: one instruction or one rom byte write per transfer
// ----------------------------------------------------------------------------
// sequence: a load transfer or a halted step goes straight to write-back; an
//   instruction passes fetch and decode, then further states for the memory bytes it needs on the single port
// throughput: one transfer at a time, next accepted once the result is registered
// reset: registers, flags and halt clear at once; ram is then cleared by a pass
//   over all RAM_DEPTH entries during which s_ready stays low
// ----------------------------------------------------------------------------
module eight_bit_cpu_core_step #(
    parameter int ROM_DEPTH = ebcpu_pkg::ROM_DEPTH_DEF,
    parameter int RAM_DEPTH = ebcpu_pkg::RAM_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [14:0] s_load_address,
    input  logic [7:0]  s_load_data,
    input  logic [7:0]  s_port_read_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_prog_counter,
    output logic [7:0]  m_acc,
    output logic [7:0]  m_reg_second,
    output logic [15:0] m_addr_pair,
    output logic [3:0]  m_flag_bits,
    output logic [7:0]  m_stack_ptr,
    output logic        m_port_write_valid,
    output logic [7:0]  m_port_number,
    output logic [7:0]  m_port_write_data,
    output logic        m_halted
);
    import ebcpu_pkg::*;

    // opcode field, bits 7..2 of the instruction byte
    localparam logic [5:0] OP_LDI  = 6'h01;
    localparam logic [5:0] OP_LDA  = 6'h02;
    localparam logic [5:0] OP_LDM  = 6'h03;
    localparam logic [5:0] OP_STA  = 6'h04;
    localparam logic [5:0] OP_STM  = 6'h05;
    localparam logic [5:0] OP_LDHL = 6'h06;
    localparam logic [5:0] OP_IN   = 6'h07;
    localparam logic [5:0] OP_OUT  = 6'h08;
    localparam logic [5:0] OP_INC  = 6'h09;
    localparam logic [5:0] OP_DEC  = 6'h0A;
    localparam logic [5:0] OP_INHL = 6'h0B;
    localparam logic [5:0] OP_DEHL = 6'h0C;
    localparam logic [5:0] OP_ADDI = 6'h0D;
    localparam logic [5:0] OP_ADDR = 6'h0E;
    localparam logic [5:0] OP_ADCI = 6'h0F;
    localparam logic [5:0] OP_ADCR = 6'h10;
    localparam logic [5:0] OP_SUBI = 6'h11;
    localparam logic [5:0] OP_SUBR = 6'h12;
    localparam logic [5:0] OP_SBCI = 6'h13;
    localparam logic [5:0] OP_SBCR = 6'h14;
    localparam logic [5:0] OP_ANDI = 6'h15;
    localparam logic [5:0] OP_ANDR = 6'h16;
    localparam logic [5:0] OP_ORI  = 6'h17;
    localparam logic [5:0] OP_ORR  = 6'h18;
    localparam logic [5:0] OP_XORI = 6'h19;
    localparam logic [5:0] OP_XORR = 6'h1A;
    localparam logic [5:0] OP_CMPI = 6'h1B;
    localparam logic [5:0] OP_CMPR = 6'h1C;
    localparam logic [5:0] OP_JMP  = 6'h1D;
    localparam logic [5:0] OP_JPHL = 6'h1E;
    localparam logic [5:0] OP_JR   = 6'h1F;
    localparam logic [5:0] OP_BRT  = 6'h20;
    localparam logic [5:0] OP_BRF  = 6'h21;
    localparam logic [5:0] OP_INA  = 6'h22;
    localparam logic [5:0] OP_OUTA = 6'h23;
    localparam logic [5:0] OP_PUSH = 6'h24;
    localparam logic [5:0] OP_POP  = 6'h25;
    localparam logic [5:0] OP_CALL = 6'h26;
    localparam logic [5:0] OP_RET  = 6'h27;
    localparam logic [5:0] OP_HALT = 6'h28;

    localparam logic [7:0] STACK_PAGE = 8'hFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_IMM,
        S_HI,
        S_LO,
        S_MEM,
        S_CALL2,
        S_CALL3,
        S_WB
    } state_t;

    // register file pick by selector field
    function automatic logic [7:0] reg_pick(input logic [1:0] sel, input logic [7:0] a,
                                            input logic [7:0] b, input logic [15:0] hl);
        logic [7:0] v;
        case (sel)
            2'd0:    v = a;
            2'd1:    v = b;
            2'd2:    v = hl[15:8];
            default: v = hl[7:0];
        endcase
        return v;
    endfunction

    // condition code c tests flag bit (3 - c) mod 4
    function automatic logic cond_hit(input logic [1:0] c, input logic [3:0] f);
        logic [1:0] bitpos;
        bitpos = 2'd3 - c;
        return f[bitpos];
    endfunction

    // alu immediate/register variants
    function automatic alu_ctl_t alu_for(input logic [5:0] opc);
        alu_ctl_t c;
        c.carry_en = 1'b0;
        c.op       = ALU_LOAD;
        case (opc)
            OP_ADDI, OP_ADDR: c.op = ALU_ADD;
            OP_ADCI, OP_ADCR: begin
                c.op = ALU_ADD;
                c.carry_en = 1'b1;
            end
            OP_SUBI, OP_SUBR, OP_CMPI, OP_CMPR: c.op = ALU_SUB;
            OP_SBCI, OP_SBCR: begin
                c.op = ALU_SUB;
                c.carry_en = 1'b1;
            end
            OP_ANDI, OP_ANDR: c.op = ALU_AND;
            OP_ORI,  OP_ORR:  c.op = ALU_OR;
            OP_XORI, OP_XORR: c.op = ALU_XOR;
            default:          c.op = ALU_LOAD;
        endcase
        return c;
    endfunction

    state_t      state_reg, state_next;
    logic [7:0]  a_reg, a_next;
    logic [7:0]  b_reg, b_next;
    logic [15:0] hl_reg, hl_next;
    logic [15:0] pc_reg, pc_next;
    logic [7:0]  sp_reg, sp_next;
    logic [3:0]  flags_reg, flags_next;
    logic        halt_reg, halt_next;
    logic [7:0]  ins_reg, ins_next;
    logic [7:0]  hi_reg, hi_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  pin_reg, pin_next;
    logic        pv_reg, pv_next;
    logic [7:0]  pnum_reg, pnum_next;
    logic [7:0]  pdata_reg, pdata_next;
    logic        m_valid_reg, m_valid_next;
    logic        m_load;

    logic [15:0] m_pc_reg;
    logic [7:0]  m_acc_reg;
    logic [7:0]  m_b_reg;
    logic [15:0] m_hl_reg;
    logic [3:0]  m_flags_reg;
    logic [7:0]  m_sp_reg;
    logic        m_pv_reg;
    logic [7:0]  m_pnum_reg;
    logic [7:0]  m_pdata_reg;
    logic        m_halt_reg;

    mem_req_t    mreq;
    logic        rom_we;
    logic [7:0]  mem_rdata;
    logic        clear_busy;

    alu_ctl_t    alu_ctl;
    logic [7:0]  alu_a;
    logic [7:0]  alu_b;
    logic [7:0]  alu_res;
    logic [3:0]  alu_flags;
    logic        alu_flag_en;

    // register write-back from decode
    logic        wr_en;
    logic [1:0]  wr_sel;
    logic        wr_from_mem;

    logic [5:0]  opc_d;
    logic [1:0]  rsel_d;
    logic [7:0]  rval_d;
    logic [5:0]  opc_i;
    logic [1:0]  rsel_i;
    logic [7:0]  rval_i;
    logic [15:0] word_lo;
    logic [15:0] ret_addr;
    logic [15:0] stk_addr;
    logic [7:0]  wr_val;

    ebcpu_mem #(
        .ROM_DEPTH (ROM_DEPTH),
        .RAM_DEPTH (RAM_DEPTH)
    ) u_mem (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (mreq),
        .load_we    (rom_we),
        .load_addr  (s_load_address),
        .load_data  (s_load_data),
        .rdata      (mem_rdata),
        .clear_busy (clear_busy)
    );

    ebcpu_alu u_alu (
        .ctl       (alu_ctl),
        .opnd_a    (alu_a),
        .opnd_b    (alu_b),
        .flags_in  (flags_reg),
        .result    (alu_res),
        .flags_out (alu_flags)
    );

    assign s_ready = (state_reg == S_IDLE) && !clear_busy;

    // decode fields: fresh byte in decode, held byte in later states
    assign opc_d    = mem_rdata[7:2];
    assign rsel_d   = mem_rdata[1:0];
    assign rval_d   = reg_pick(rsel_d, a_reg, b_reg, hl_reg);
    assign opc_i    = ins_reg[7:2];
    assign rsel_i   = ins_reg[1:0];
    assign rval_i   = reg_pick(rsel_i, a_reg, b_reg, hl_reg);
    assign word_lo  = {hi_reg, mem_rdata};
    assign ret_addr = pc_reg + 16'd2;
    assign stk_addr = {STACK_PAGE, sp_reg};

    always_comb begin
        state_next   = state_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        hl_next      = hl_reg;
        pc_next      = pc_reg;
        sp_next      = sp_reg;
        flags_next   = flags_reg;
        halt_next    = halt_reg;
        ins_next     = ins_reg;
        hi_next      = hi_reg;
        addr_next    = addr_reg;
        pin_next     = pin_reg;
        pv_next      = pv_reg;
        pnum_next    = pnum_reg;
        pdata_next   = pdata_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_load       = 1'b0;
        mreq         = '0;
        rom_we       = 1'b0;
        alu_ctl.op       = ALU_LOAD;
        alu_ctl.carry_en = 1'b0;
        alu_a        = a_reg;
        alu_b        = 8'd0;
        alu_flag_en  = 1'b0;
        wr_en        = 1'b0;
        wr_sel       = 2'd0;
        wr_from_mem  = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    pv_next    = 1'b0;
                    pnum_next  = 8'd0;
                    pdata_next = 8'd0;
                    pin_next   = s_port_read_data;
                    if (s_kind) begin
                        rom_we     = 1'b1;
                        state_next = S_WB;
                    end else if (halt_reg) begin
                        state_next = S_WB;
                    end else begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                mreq.rd    = 1'b1;
                mreq.addr  = pc_reg;
                pc_next    = pc_reg + 16'd1;
                state_next = S_DECODE;
            end
            S_DECODE: begin
                ins_next   = mem_rdata;
                state_next = S_WB;
                case (opc_d)
                    OP_LDI, OP_IN, OP_OUT, OP_ADDI, OP_ADCI, OP_SUBI, OP_SBCI,
                    OP_ANDI, OP_ORI, OP_XORI, OP_CMPI, OP_JR: begin
                        mreq.rd    = 1'b1;
                        mreq.addr  = pc_reg;
                        pc_next    = pc_reg + 16'd1;
                        state_next = S_IMM;
                    end
                    OP_BRT, OP_BRF: begin
                        if (cond_hit(rsel_d, flags_reg) == (opc_d == OP_BRT)) begin
                            mreq.rd    = 1'b1;
                            mreq.addr  = pc_reg;
                            state_next = S_IMM;
                        end
                        // not taken: offset byte skipped
                        pc_next = pc_reg + 16'd1;
                    end
                    OP_LDA, OP_STA, OP_LDHL, OP_JMP: begin
                        mreq.rd    = 1'b1;
                        mreq.addr  = pc_reg;
                        addr_next  = pc_reg + 16'd1;
                        pc_next    = pc_reg + 16'd2;
                        state_next = S_HI;
                    end
                    OP_LDM: begin
                        mreq.rd    = 1'b1;
                        mreq.addr  = hl_reg;
                        state_next = S_MEM;
                    end
                    OP_STM: begin
                        mreq.wr    = 1'b1;
                        mreq.addr  = hl_reg;
                        mreq.wdata = rval_d;
                    end
                    OP_INC, OP_DEC: begin
                        alu_ctl.op  = (opc_d == OP_INC) ? ALU_INC : ALU_DEC;
                        alu_a       = rval_d;
                        alu_flag_en = 1'b1;
                        wr_en       = 1'b1;
                        wr_sel      = rsel_d;
                    end
                    OP_INHL: hl_next = hl_reg + 16'd1;
                    OP_DEHL: hl_next = hl_reg - 16'd1;
                    OP_ADDR, OP_ADCR, OP_SUBR, OP_SBCR, OP_ANDR, OP_ORR, OP_XORR: begin
                        alu_ctl     = alu_for(opc_d);
                        alu_b       = rval_d;
                        alu_flag_en = 1'b1;
                        wr_en       = 1'b1;
                        wr_sel      = 2'd0;
                    end
                    OP_CMPR: begin
                        alu_ctl     = alu_for(opc_d);
                        alu_b       = rval_d;
                        alu_flag_en = 1'b1;
                    end
                    OP_JPHL: pc_next = hl_reg;
                    OP_INA: begin
                        pnum_next   = a_reg;
                        alu_b       = pin_reg;
                        alu_flag_en = 1'b1;
                        wr_en       = 1'b1;
                        wr_sel      = rsel_d;
                    end
                    OP_OUTA: begin
                        pnum_next  = a_reg;
                        pv_next    = 1'b1;
                        pdata_next = rval_d;
                    end
                    OP_PUSH: begin
                        sp_next    = sp_reg - 8'd1;
                        mreq.wr    = 1'b1;
                        mreq.addr  = {STACK_PAGE, sp_reg - 8'd1};
                        mreq.wdata = rval_d;
                    end
                    OP_POP: begin
                        mreq.rd    = 1'b1;
                        mreq.addr  = stk_addr;
                        sp_next    = sp_reg + 8'd1;
                        state_next = S_MEM;
                    end
                    OP_CALL: begin
                        // return address high byte now, low byte next cycle
                        sp_next    = sp_reg - 8'd2;
                        mreq.wr    = 1'b1;
                        mreq.addr  = {STACK_PAGE, sp_reg - 8'd2};
                        mreq.wdata = ret_addr[15:8];
                        hi_next    = ret_addr[7:0];
                        addr_next  = {STACK_PAGE, sp_reg - 8'd2} + 16'd1;
                        state_next = S_CALL2;
                    end
                    OP_RET: begin
                        mreq.rd    = 1'b1;
                        mreq.addr  = stk_addr;
                        addr_next  = stk_addr + 16'd1;
                        sp_next    = sp_reg + 8'd2;
                        state_next = S_HI;
                    end
                    OP_HALT: halt_next = 1'b1;
                    default: ;
                endcase
            end
            S_IMM: begin
                state_next = S_WB;
                case (opc_i)
                    OP_LDI: begin
                        alu_b       = mem_rdata;
                        alu_flag_en = 1'b1;
                        wr_en       = 1'b1;
                        wr_sel      = rsel_i;
                    end
                    OP_IN: begin
                        pnum_next   = mem_rdata;
                        alu_b       = pin_reg;
                        alu_flag_en = 1'b1;
                        wr_en       = 1'b1;
                        wr_sel      = rsel_i;
                    end
                    OP_OUT: begin
                        pnum_next  = mem_rdata;
                        pv_next    = 1'b1;
                        pdata_next = rval_i;
                    end
                    OP_JR, OP_BRT, OP_BRF: begin
                        pc_next = pc_reg + {{8{mem_rdata[7]}}, mem_rdata};
                    end
                    OP_CMPI: begin
                        alu_ctl     = alu_for(opc_i);
                        alu_b       = mem_rdata;
                        alu_flag_en = 1'b1;
                    end
                    default: begin
                        alu_ctl     = alu_for(opc_i);
                        alu_b       = mem_rdata;
                        alu_flag_en = 1'b1;
                        wr_en       = 1'b1;
                        wr_sel      = 2'd0;
                    end
                endcase
            end
            S_HI: begin
                hi_next    = mem_rdata;
                mreq.rd    = 1'b1;
                mreq.addr  = addr_reg;
                state_next = S_LO;
            end
            S_LO: begin
                state_next = S_WB;
                case (opc_i)
                    OP_LDA: begin
                        mreq.rd    = 1'b1;
                        mreq.addr  = word_lo;
                        state_next = S_MEM;
                    end
                    OP_STA: begin
                        mreq.wr    = 1'b1;
                        mreq.addr  = word_lo;
                        mreq.wdata = rval_i;
                    end
                    OP_LDHL: hl_next = word_lo;
                    default: pc_next = word_lo;
                endcase
            end
            S_MEM: begin
                state_next = S_WB;
                wr_en      = 1'b1;
                wr_sel     = rsel_i;
                if (opc_i == OP_POP) begin
                    wr_from_mem = 1'b1;
                end else begin
                    alu_b       = mem_rdata;
                    alu_flag_en = 1'b1;
                end
            end
            S_CALL2: begin
                mreq.wr    = 1'b1;
                mreq.addr  = addr_reg;
                mreq.wdata = hi_reg;
                state_next = S_CALL3;
            end
            S_CALL3: begin
                mreq.rd    = 1'b1;
                mreq.addr  = pc_reg;
                addr_next  = pc_reg + 16'd1;
                pc_next    = pc_reg + 16'd2;
                state_next = S_HI;
            end
            S_WB: begin
                // result register free or being drained this cycle
                if (!m_valid_reg || m_ready) begin
                    m_load       = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        wr_val = wr_from_mem ? mem_rdata : alu_res;
        if (alu_flag_en) begin
            flags_next = alu_flags;
        end
        if (wr_en) begin
            case (wr_sel)
                2'd0:    a_next = wr_val;
                2'd1:    b_next = wr_val;
                2'd2:    hl_next = {wr_val, hl_reg[7:0]};
                default: hl_next = {hl_reg[15:8], wr_val};
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            a_reg       <= 8'd0;
            b_reg       <= 8'd0;
            hl_reg      <= 16'd0;
            pc_reg      <= 16'd0;
            sp_reg      <= 8'd0;
            flags_reg   <= 4'd0;
            halt_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            hl_reg      <= hl_next;
            pc_reg      <= pc_next;
            sp_reg      <= sp_next;
            flags_reg   <= flags_next;
            halt_reg    <= halt_next;
            m_valid_reg <= m_valid_next;
        end
        // payload, no reset needed
        ins_reg   <= ins_next;
        hi_reg    <= hi_next;
        addr_reg  <= addr_next;
        pin_reg   <= pin_next;
        pv_reg    <= pv_next;
        pnum_reg  <= pnum_next;
        pdata_reg <= pdata_next;
        if (m_load) begin
            m_pc_reg    <= pc_reg;
            m_acc_reg   <= a_reg;
            m_b_reg     <= b_reg;
            m_hl_reg    <= hl_reg;
            m_flags_reg <= flags_reg;
            m_sp_reg    <= sp_reg;
            m_pv_reg    <= pv_reg;
            m_pnum_reg  <= pnum_reg;
            m_pdata_reg <= pdata_reg;
            m_halt_reg  <= halt_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_prog_counter     = m_pc_reg;
    assign m_acc              = m_acc_reg;
    assign m_reg_second       = m_b_reg;
    assign m_addr_pair        = m_hl_reg;
    assign m_flag_bits        = m_flags_reg;
    assign m_stack_ptr        = m_sp_reg;
    assign m_port_write_valid = m_pv_reg;
    assign m_port_number      = m_pnum_reg;
    assign m_port_write_data  = m_pdata_reg;
    assign m_halted           = m_halt_reg;

    // no transfer taken while ram clears
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !s_ready)
        else $error("input accepted during ram clearing pass");

    // one item in flight at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted while one is in flight");

    // halt only leaves through reset
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg)
        else $error("halt mark cleared without reset");

    // a result is registered only when the output side is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before transfer");

endmodule

FILE: rtl/ebcpu_alu.sv
// ----------------------------------------------------------------------------
// ebcpu_alu
// shared 8-bit arithmetic and logic unit with flag generation
// ----------------------------------------------------------------------------
module ebcpu_alu (
    input  ebcpu_pkg::alu_ctl_t ctl,
    input  logic [7:0]          opnd_a,
    input  logic [7:0]          opnd_b,
    input  logic [3:0]          flags_in,
    output logic [7:0]          result,
    output logic [3:0]          flags_out
);
    import ebcpu_pkg::*;

    logic [7:0] bx;
    logic [8:0] sum9;
    logic [7:0] diff;

    always_comb begin
        // operand plus carry wraps at 8 bits
        bx   = opnd_b + {7'd0, ctl.carry_en & flags_in[FL_C]};
        sum9 = {1'b0, opnd_a} + {1'b0, bx};
        diff = opnd_a - bx;
        result    = opnd_b;
        flags_out = flags_in;
        unique case (ctl.op)
            ALU_LOAD: begin
                result = opnd_b;
                flags_out[FL_Z] = (opnd_b == 8'd0);
            end
            ALU_ADD: begin
                result = sum9[7:0];
                flags_out[FL_Z] = (sum9[7:0] == 8'd0);
                flags_out[FL_C] = sum9[8];
                flags_out[FL_N] = sum9[7];
                flags_out[FL_V] = ~(opnd_a[7] ^ bx[7]) & (opnd_a[7] ^ sum9[7]);
            end
            ALU_SUB: begin
                result = diff;
                flags_out[FL_Z] = (diff == 8'd0);
                flags_out[FL_C] = (bx > opnd_a);
                flags_out[FL_N] = diff[7];
                flags_out[FL_V] = (opnd_a[7] ^ bx[7]) & (opnd_a[7] ^ diff[7]);
            end
            ALU_AND: begin
                result = opnd_a & opnd_b;
                flags_out[FL_Z] = ((opnd_a & opnd_b) == 8'd0);
            end
            ALU_OR: begin
                result = opnd_a | opnd_b;
                flags_out[FL_Z] = ((opnd_a | opnd_b) == 8'd0);
            end
            ALU_XOR: begin
                result = opnd_a ^ opnd_b;
                flags_out[FL_Z] = ((opnd_a ^ opnd_b) == 8'd0);
            end
            ALU_INC: begin
                result = opnd_a + 8'd1;
                flags_out[FL_Z] = (opnd_a == 8'hFF);
                flags_out[FL_C] = (opnd_a == 8'hFF);
            end
            ALU_DEC: begin
                result = opnd_a - 8'd1;
                flags_out[FL_C] = (opnd_a == 8'd0);
                flags_out[FL_Z] = (opnd_a == 8'd1);
            end
            default: begin
                result    = opnd_b;
                flags_out = flags_in;
            end
        endcase
    end

endmodule

FILE: rtl/ebcpu_mem.sv
// ----------------------------------------------------------------------------
// ebcpu_mem
// program rom and data ram behind one byte port, with ram clearing pass
// ----------------------------------------------------------------------------
module ebcpu_mem #(
    parameter int ROM_DEPTH = ebcpu_pkg::ROM_DEPTH_DEF,
    parameter int RAM_DEPTH = ebcpu_pkg::RAM_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ebcpu_pkg::mem_req_t req,
    input  logic                load_we,
    input  logic [14:0]         load_addr,
    input  logic [7:0]          load_data,
    output logic [7:0]          rdata,
    output logic                clear_busy
);
    import ebcpu_pkg::*;

    localparam int ROM_AW = $clog2(ROM_DEPTH);
    localparam int RAM_AW = $clog2(RAM_DEPTH);

    logic [7:0] rom_mem [ROM_DEPTH];
    logic [7:0] ram_mem [RAM_DEPTH];

    logic [7:0]        rom_q;
    logic [7:0]        ram_q;
    logic              rd_rom_reg;
    logic              rd_ram_reg;
    logic              clr_reg;
    logic [RAM_AW-1:0] clr_cnt_reg;

    logic              rom_hit;
    logic              ram_hit;
    logic              load_hit;

    assign rom_hit  = !req.addr[15] && ({1'b0, req.addr[14:0]} < 16'(ROM_DEPTH));
    assign ram_hit  =  req.addr[15] && ({1'b0, req.addr[14:0]} < 16'(RAM_DEPTH));
    assign load_hit = ({1'b0, load_addr} < 16'(ROM_DEPTH));

    always_ff @(posedge aclk) begin
        if (load_we && load_hit) begin
            rom_mem[load_addr[ROM_AW-1:0]] <= load_data;
        end
        if (req.rd) begin
            rom_q <= rom_mem[req.addr[ROM_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_reg) begin
            ram_mem[clr_cnt_reg] <= 8'd0;
        end else if (req.wr && ram_hit) begin
            ram_mem[req.addr[RAM_AW-1:0]] <= req.wdata;
        end
        if (req.rd) begin
            ram_q <= ram_mem[req.addr[RAM_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_rom_reg  <= 1'b0;
            rd_ram_reg  <= 1'b0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end else begin
            rd_rom_reg <= req.rd && rom_hit;
            rd_ram_reg <= req.rd && ram_hit;
            if (clr_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == RAM_AW'(RAM_DEPTH - 1)) begin
                    clr_reg <= 1'b0;
                end
            end
        end
    end

    // out-of-range reads give zero
    assign rdata      = rd_rom_reg ? rom_q : (rd_ram_reg ? ram_q : 8'd0);
    assign clear_busy = clr_reg;

endmodule
